// File: rtl/ppbl_pkg.sv
package ppbl_pkg;

  localparam int NUM_SLOTS_DEF = 16;
  localparam int ID_BITS_DEF   = 32;
  localparam int PIN_BITS_DEF  = 8;

  localparam logic [4:0] SLOT_LIMIT_RST = 5'd16;

  typedef enum logic [2:0] {
    MODE_FETCH    = 3'd0,
    MODE_NEW      = 3'd1,
    MODE_UNPIN    = 3'd2,
    MODE_PREFETCH = 3'd3,
    MODE_FLUSH    = 3'd4
  } ppbl_mode_t;

  typedef enum logic [2:0] {
    ST_HIT        = 3'd0,
    ST_MISS       = 3'd1,
    ST_NO_VICTIM  = 3'd2,
    ST_PIN_OVF    = 3'd3,
    ST_BAD_UNPIN  = 3'd4,
    ST_CACHED     = 3'd5
  } ppbl_status_t;

  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_READ  = 2'd1,
    KIND_WRITE = 2'd2
  } ppbl_kind_t;

  // rank update that every unselected evictable cell applies
  typedef enum logic [1:0] {
    UPD_NONE,
    UPD_DROP,
    UPD_ADD
  } ppbl_upd_t;

  typedef struct packed {
    ppbl_upd_t op;
    logic      load_page;
    logic      new_ev;
  } ppbl_ctl_t;

  typedef struct packed {
    logic valid;
    logic hit;
    logic victim;
    logic free;
    logic ev;
  } ppbl_stat_t;

endpackage

// File: rtl/pinned_page_buffer_pool_lru_unit.sv
// an accepted input beat passes S_LOOK, then S_APPLY, which waits on out_ready
//   to register its result beat; a new item is accepted only back in S_IDLE,
//   set by the single broadcast compare and update over the slot cells
// each item in modes 0 to 4 gives one result beat; modes 5 to 7 give none
// reset (rst_n low, synchronous): all slots empty, unpinned, slot_limit 16
module pinned_page_buffer_pool_lru_unit #(
  parameter int NUM_SLOTS = ppbl_pkg::NUM_SLOTS_DEF,
  parameter int ID_BITS   = ppbl_pkg::ID_BITS_DEF,
  parameter int PIN_BITS  = ppbl_pkg::PIN_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [4:0]  cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_mode,
  input  logic [31:0] in_page_id,
  input  logic [3:0]  in_slot,
  input  logic        in_dirty,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  out_result_slot,
  output logic [31:0] out_request_page,
  output logic [1:0]  out_request_kind,
  output logic [2:0]  out_status,
  output logic        out_last
);

  localparam int RW = $clog2(NUM_SLOTS);
  localparam int CW = $clog2(NUM_SLOTS + 1);
  localparam int IW = (RW > 4) ? RW : 4;
  localparam logic [PIN_BITS-1:0] PIN_MAX = '1;

  typedef enum logic [1:0] {S_IDLE, S_LOOK, S_APPLY} state_t;

  state_t              state_r;
  logic [4:0]          limit_r;
  logic [2:0]          mode_r;
  logic [ID_BITS-1:0]  id_r;
  logic [3:0]          sl_r;
  logic                dirty_r;
  logic [CW-1:0]       cnt_r, cnt_nxt;
  logic [CW-1:0]       ev_cnt_r, ev_cnt_nxt;

  logic                hit_any_r, vic_any_r, room_r, sl_ok_r;
  logic [RW-1:0]       hit_idx_r, vic_idx_r, free_idx_r, sl_idx_r;
  logic [PIN_BITS-1:0] rd_pin_r;
  logic [ID_BITS-1:0]  rd_page_r;
  logic [RW-1:0]       rd_rank_r;
  logic                rd_valid_r, rd_ev_r;

  logic                out_valid_r;
  logic [3:0]          o_slot_r;
  logic [31:0]         o_page_r;
  logic [1:0]          o_kind_r;
  logic [2:0]          o_status_r;

  ppbl_pkg::ppbl_stat_t stat_v [NUM_SLOTS];
  logic [PIN_BITS-1:0] pin_v  [NUM_SLOTS];
  logic [ID_BITS-1:0]  page_v [NUM_SLOTS];
  logic [RW-1:0]       rank_v [NUM_SLOTS];
  logic [NUM_SLOTS:0]  free_c;
  logic [NUM_SLOTS-1:0] hit_vec, vic_vec, ev_vec, sel_vec;

  ppbl_pkg::ppbl_ctl_t ctl;
  logic                sel_en;
  logic [RW-1:0]       sel_idx, ref_rank, vic_rank;
  logic [PIN_BITS-1:0] new_pin;
  logic                emit, go;
  logic [3:0]          e_slot;
  logic [31:0]         e_page;
  logic [1:0]          e_kind;
  logic [2:0]          e_status;

  logic [RW-1:0]       hit_idx, vic_idx, free_idx, rd_idx, sl_idx;
  logic                hit_any, vic_any;
  logic [IW-1:0]       sl_ext;

  assign free_c[0] = 1'b0;
  assign vic_rank  = RW'(ev_cnt_r - CW'(1));

  for (genvar g = 0; g < NUM_SLOTS; g++) begin : g_cell
    ppbl_cell #(
      .NUM_SLOTS (NUM_SLOTS),
      .ID_BITS   (ID_BITS),
      .PIN_BITS  (PIN_BITS)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .sel      (sel_vec[g]),
      .ctl      (ctl),
      .new_pin  (new_pin),
      .load_id  (id_r),
      .ref_rank (ref_rank),
      .vic_rank (vic_rank),
      .cmp_id   (id_r),
      .free_in  (free_c[g]),
      .free_out (free_c[g+1]),
      .stat     (stat_v[g]),
      .pin      (pin_v[g]),
      .page     (page_v[g]),
      .rank     (rank_v[g])
    );
    assign hit_vec[g] = stat_v[g].hit;
    assign vic_vec[g] = stat_v[g].victim;
    assign ev_vec[g]  = stat_v[g].ev;
    assign sel_vec[g] = sel_en && (sel_idx == RW'(g));
  end

  // lookup encode, one read port at the unpin slot or the hit slot
  always_comb begin
    hit_idx  = '0;
    vic_idx  = '0;
    free_idx = '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (hit_vec[i]) hit_idx = hit_idx | RW'(i);
      if (vic_vec[i]) vic_idx = vic_idx | RW'(i);
      if (stat_v[i].free) free_idx = free_idx | RW'(i);
    end
    hit_any = |hit_vec;
    vic_any = |vic_vec;
    sl_ext  = IW'(sl_r);
    sl_idx  = sl_ext[RW-1:0];
    rd_idx  = (mode_r == ppbl_pkg::MODE_UNPIN) ? sl_idx : hit_idx;
  end

  assign go = (state_r == S_APPLY) && (!out_valid_r || out_ready);

  always_comb begin
    sel_en     = 1'b0;
    sel_idx    = '0;
    ctl.op     = ppbl_pkg::UPD_NONE;
    ctl.load_page = 1'b0;
    ctl.new_ev = 1'b0;
    new_pin    = '0;
    ref_rank   = rd_rank_r;
    emit       = 1'b1;
    e_slot     = 4'(hit_idx_r);
    e_page     = 32'(id_r);
    e_kind     = ppbl_pkg::KIND_NONE;
    e_status   = ppbl_pkg::ST_HIT;
    cnt_nxt    = cnt_r;
    ev_cnt_nxt = ev_cnt_r;
    case (mode_r)
      ppbl_pkg::MODE_FETCH, ppbl_pkg::MODE_NEW, ppbl_pkg::MODE_PREFETCH: begin
        if (hit_any_r) begin
          if (mode_r != ppbl_pkg::MODE_FETCH) begin
            e_status = ppbl_pkg::ST_CACHED;
          end else if (rd_pin_r == PIN_MAX) begin
            e_status = ppbl_pkg::ST_PIN_OVF;
          end else begin
            sel_en  = 1'b1;
            sel_idx = hit_idx_r;
            new_pin = rd_pin_r + PIN_BITS'(1);
            if (rd_ev_r) begin
              ctl.op     = ppbl_pkg::UPD_DROP;
              ev_cnt_nxt = ev_cnt_r - CW'(1);
            end
          end
        end else if (!room_r && !vic_any_r) begin
          e_slot   = '0;
          e_status = ppbl_pkg::ST_NO_VICTIM;
        end else begin
          sel_en        = 1'b1;
          ctl.load_page = 1'b1;
          e_status      = ppbl_pkg::ST_MISS;
          if (room_r) begin
            sel_idx = free_idx_r;
            cnt_nxt = cnt_r + CW'(1);
          end else begin
            sel_idx    = vic_idx_r;
            ev_cnt_nxt = ev_cnt_r - CW'(1);
          end
          e_slot = 4'(sel_idx);
          case (mode_r)
            ppbl_pkg::MODE_FETCH: begin
              new_pin = PIN_BITS'(1);
              e_kind  = ppbl_pkg::KIND_READ;
            end
            ppbl_pkg::MODE_NEW: begin
              new_pin = PIN_BITS'(1);
            end
            default: begin
              ctl.op     = ppbl_pkg::UPD_ADD;
              ctl.new_ev = 1'b1;
              e_kind     = ppbl_pkg::KIND_READ;
              if (room_r) begin
                ev_cnt_nxt = ev_cnt_r + CW'(1);
              end else begin
                ev_cnt_nxt = ev_cnt_r;
              end
            end
          endcase
        end
      end
      ppbl_pkg::MODE_UNPIN: begin
        e_slot = sl_r;
        if (!sl_ok_r || !rd_valid_r || rd_pin_r == '0) begin
          e_status = ppbl_pkg::ST_BAD_UNPIN;
        end else begin
          sel_en  = 1'b1;
          sel_idx = sl_idx_r;
          new_pin = rd_pin_r - PIN_BITS'(1);
          e_page  = 32'(rd_page_r);
          e_kind  = dirty_r ? ppbl_pkg::KIND_WRITE : ppbl_pkg::KIND_NONE;
          if (rd_pin_r == PIN_BITS'(1)) begin
            ctl.op     = ppbl_pkg::UPD_ADD;
            ctl.new_ev = 1'b1;
            ev_cnt_nxt = ev_cnt_r + CW'(1);
          end
        end
      end
      ppbl_pkg::MODE_FLUSH: begin
        e_slot = '0;
        e_page = '0;
      end
      default: emit = 1'b0;
    endcase
    if (!go) begin
      sel_en = 1'b0;
      ctl.op = ppbl_pkg::UPD_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      limit_r     <= ppbl_pkg::SLOT_LIMIT_RST;
      cnt_r       <= '0;
      ev_cnt_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        limit_r <= cfg_wdata;
      end
      if (go && emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            state_r <= S_LOOK;
          end
        end
        S_LOOK: state_r <= S_APPLY;
        S_APPLY: begin
          if (go) begin
            state_r  <= S_IDLE;
            cnt_r    <= cnt_nxt;
            ev_cnt_r <= ev_cnt_nxt;
            if (emit) begin
              o_slot_r   <= e_slot;
              o_page_r   <= e_page;
              o_kind_r   <= e_kind;
              o_status_r <= e_status;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      mode_r  <= in_mode;
      id_r    <= ID_BITS'(in_page_id);
      sl_r    <= in_slot;
      dirty_r <= in_dirty;
    end
    if (state_r == S_LOOK) begin
      hit_any_r  <= hit_any;
      vic_any_r  <= vic_any;
      hit_idx_r  <= hit_idx;
      vic_idx_r  <= vic_idx;
      free_idx_r <= free_idx;
      sl_idx_r   <= sl_idx;
      sl_ok_r    <= 32'(sl_r) < NUM_SLOTS;
      room_r     <= (32'(cnt_r) < 32'(limit_r)) && (32'(cnt_r) < NUM_SLOTS);
      rd_pin_r   <= pin_v[rd_idx];
      rd_page_r  <= page_v[rd_idx];
      rd_rank_r  <= rank_v[rd_idx];
      rd_valid_r <= stat_v[rd_idx].valid;
      rd_ev_r    <= stat_v[rd_idx].ev;
    end
  end

  assign in_ready         = (state_r == S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_result_slot  = o_slot_r;
  assign out_request_page = o_page_r;
  assign out_request_kind = o_kind_r;
  assign out_status       = o_status_r;
  assign out_last         = 1'b1;

  a_ev_count: assert property (@(posedge clk) disable iff (!rst_n)
    32'(ev_cnt_r) == $countones(ev_vec))
    else $error("evictable count out of step with cells");

  a_ev_le_used: assert property (@(posedge clk) disable iff (!rst_n)
    ev_cnt_r <= cnt_r)
    else $error("more evictable than filled slots");

  a_one_victim: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(vic_vec))
    else $error("lru ranks not distinct");

  a_one_hit: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(hit_vec))
    else $error("page cached in two slots");

endmodule

// File: rtl/ppbl_cell.sv
module ppbl_cell #(
  parameter int NUM_SLOTS = ppbl_pkg::NUM_SLOTS_DEF,
  parameter int ID_BITS   = ppbl_pkg::ID_BITS_DEF,
  parameter int PIN_BITS  = ppbl_pkg::PIN_BITS_DEF,
  localparam int RW = $clog2(NUM_SLOTS)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                sel,
  input  ppbl_pkg::ppbl_ctl_t ctl,
  input  logic [PIN_BITS-1:0] new_pin,
  input  logic [ID_BITS-1:0]  load_id,
  input  logic [RW-1:0]       ref_rank,
  input  logic [RW-1:0]       vic_rank,
  input  logic [ID_BITS-1:0]  cmp_id,
  input  logic                free_in,
  output logic                free_out,
  output ppbl_pkg::ppbl_stat_t stat,
  output logic [PIN_BITS-1:0] pin,
  output logic [ID_BITS-1:0]  page,
  output logic [RW-1:0]       rank
);

  logic                valid_r, valid_nxt;
  logic [ID_BITS-1:0]  page_r, page_nxt;
  logic [PIN_BITS-1:0] pin_r, pin_nxt;
  logic                ev_r, ev_nxt;
  logic [RW-1:0]       rank_r, rank_nxt;

  always_comb begin
    valid_nxt = valid_r;
    page_nxt  = page_r;
    pin_nxt   = pin_r;
    ev_nxt    = ev_r;
    rank_nxt  = rank_r;
    if (sel) begin
      valid_nxt = 1'b1;
      if (ctl.load_page) begin
        page_nxt = load_id;
      end
      pin_nxt  = new_pin;
      ev_nxt   = ctl.new_ev;
      rank_nxt = '0;
    end else if (ev_r) begin
      case (ctl.op)
        ppbl_pkg::UPD_DROP: begin
          if (rank_r > ref_rank) begin
            rank_nxt = rank_r - RW'(1);
          end
        end
        ppbl_pkg::UPD_ADD: rank_nxt = rank_r + RW'(1);
        default: rank_nxt = rank_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      pin_r   <= '0;
      ev_r    <= 1'b0;
      rank_r  <= '0;
    end else begin
      valid_r <= valid_nxt;
      pin_r   <= pin_nxt;
      ev_r    <= ev_nxt;
      rank_r  <= rank_nxt;
    end
    page_r <= page_nxt;
  end

  assign free_out    = free_in | ~valid_r;
  assign stat.valid  = valid_r;
  assign stat.hit    = valid_r && (page_r == cmp_id);
  assign stat.victim = ev_r && (rank_r == vic_rank);
  assign stat.free   = ~valid_r & ~free_in;
  assign stat.ev     = ev_r;
  assign pin         = pin_r;
  assign page        = page_r;
  assign rank        = rank_r;

endmodule
